// ===== rtl/tcadd_pkg.sv =====
// shared types, constants and helpers for the time code millisecond adder
package tcadd_pkg;

  localparam int unsigned MS_W = 27;

  localparam logic [MS_W-1:0] DAY_MS_NORM = 27'd86400000;
  localparam logic [MS_W-1:0] DAY_MS_POS  = 27'd86401000;
  localparam logic [MS_W-1:0] DAY_MS_NEG  = 27'd86399000;

  // 86400000 = 1024 * 84375; quotient by reciprocal of 84375 scaled by 2^40
  localparam int unsigned     DIV_PRE_SH = 10;
  localparam int unsigned     RECIP_SH   = 40;
  localparam logic [23:0]     RECIP      = 24'd13031250;

  // next-day leap register codes
  localparam logic [1:0] LEAP_NONE = 2'b00;
  localparam logic [1:0] LEAP_POS  = 2'b01;
  localparam logic [1:0] LEAP_NEG  = 2'b11;

  // flag codes
  localparam logic [3:0] FLAG_POS  = 4'b1000;
  localparam logic [3:0] FLAG_NEG  = 4'b0100;
  localparam logic [3:0] FLAG_NONE = 4'b0000;

  typedef logic [MS_W-1:0] ms_t;

  typedef struct packed {
    logic       v;
    logic       inday;
    logic       back;
    logic       two;
    logic [7:0] ycode;
    logic [7:0] dlow;
    logic [3:0] flags;
    ms_t        ms_in;
    ms_t        lim;
    logic [3:0] ocode;
  } ctx_t;

  // year offset from 1970, valid for 1969..2098 where the gregorian rule is every fourth year
  function automatic logic [8:0] year_len(input logic signed [8:0] y);
    logic [8:0] n;
    n = (y[1:0] == 2'b10) ? 9'd366 : 9'd365;
    return n;
  endfunction

endpackage

// ===== rtl/tcadd_ifs.sv =====
// request channel interfaces for the time code adder
interface tcadd_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         year_code;
  logic [7:0]         day_low;
  logic [26:0]        day_ms;
  logic [3:0]         leap_flags;
  logic signed [31:0] add_ms;
  modport source (output valid, year_code, day_low, day_ms, leap_flags, add_ms, input ready);
  modport sink (input valid, year_code, day_low, day_ms, leap_flags, add_ms, output ready);
endinterface

interface tcadd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  new_year_code;
  logic [7:0]  new_day_low;
  logic [26:0] new_day_ms;
  logic [3:0]  new_leap_flags;
  modport source (output valid, new_year_code, new_day_low, new_day_ms, new_leap_flags,
                  input ready);
  modport sink (input valid, new_year_code, new_day_low, new_day_ms, new_leap_flags,
                output ready);
endinterface

interface tcadd_cfg_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] next_day_leap;
  modport source (output valid, next_day_leap, input ready);
  modport sink (input valid, next_day_leap, output ready);
endinterface

// ===== rtl/tcadd_div.sv =====
// three stage divide by one day of milliseconds, quotient and remainder
module tcadd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tcadd_pkg::ctx_t   ctx_i,
  input  logic [32:0]       x_i,
  output tcadd_pkg::ctx_t   ctx_o,
  output logic [6:0]        q_o,
  output tcadd_pkg::ms_t    r_o
);

  tcadd_pkg::ctx_t d1_ctx_r, d2_ctx_r, d3_ctx_r;
  logic [32:0] d1_x_r, d2_x_r;
  logic [46:0] d1_p_r;
  logic [46:0] p_nxt;
  logic [6:0]  q_nxt;
  logic [6:0]  d2_q_r, d3_q_r;
  logic [33:0] qd_nxt;
  logic [33:0] d2_qd_r;
  logic [32:0] diff_nxt;
  tcadd_pkg::ms_t d3_r_r;

  assign p_nxt    = 47'(x_i[32:tcadd_pkg::DIV_PRE_SH]) * 47'(tcadd_pkg::RECIP);
  assign q_nxt    = d1_p_r[46:tcadd_pkg::RECIP_SH];
  assign qd_nxt   = 34'(q_nxt) * 34'(tcadd_pkg::DAY_MS_NORM);
  assign diff_nxt = d2_x_r - d2_qd_r[32:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_ctx_r <= '0;
      d2_ctx_r <= '0;
      d3_ctx_r <= '0;
    end else if (en) begin
      d1_ctx_r <= ctx_i;
      d2_ctx_r <= d1_ctx_r;
      d3_ctx_r <= d2_ctx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_x_r  <= x_i;
      d1_p_r  <= p_nxt;
      d2_x_r  <= d1_x_r;
      d2_q_r  <= q_nxt;
      d2_qd_r <= qd_nxt;
      d3_q_r  <= d2_q_r;
      d3_r_r  <= diff_nxt[26:0];
    end
  end

  assign ctx_o = d3_ctx_r;
  assign q_o   = d3_q_r;
  assign r_o   = d3_r_r;

endmodule

// ===== rtl/time_code_add_milliseconds.sv =====
// top level of the time code millisecond adder
//
//   channel | direction | payload
//   in_if   | sink      | year_code, day_low, day_ms, leap_flags, add_ms
//   out_if  | source    | new_year_code, new_day_low, new_day_ms, new_leap_flags
//   cfg_if  | sink      | next_day_leap
//
// one request per cycle while the pipeline advances, that is while out_if.ready is high or stage 9 is empty
// the day count comes from a three stage reciprocal divider in the middle
// rst_n clears all valid bits and the next-day leap setting
// an output stall holds the whole pipeline; in_if.ready drops with it
module time_code_add_milliseconds (
  input logic         clk,
  input logic         rst_n,
  tcadd_cfg_if.sink   cfg_if,
  tcadd_in_if.sink    in_if,
  tcadd_out_if.source out_if
);

  logic [1:0] ndl_r;
  logic       adv;

  // stage 1
  logic signed [33:0] sum_nxt;
  tcadd_pkg::ms_t     lim_nxt, lim2_nxt;
  logic [3:0]         ocode_nxt;
  logic               s1_v_r;
  logic [7:0]         s1_ycode_r, s1_dlow_r;
  logic [3:0]         s1_flags_r, s1_ocode_r;
  logic signed [33:0] s1_sum_r;
  tcadd_pkg::ms_t     s1_lim_r, s1_lim2_r;

  // stage 2
  logic               s2_v_r, s2_inday_r, s2_back_r;
  logic [7:0]         s2_ycode_r, s2_dlow_r;
  logic [3:0]         s2_flags_r, s2_ocode_r;
  logic signed [33:0] s2_r1_r;
  logic [32:0]        s2_xb_r;
  tcadd_pkg::ms_t     s2_sum_lo_r, s2_lim_r, s2_lim2_r;

  // stage 3
  logic signed [33:0] x2_nxt;
  logic               two_nxt;
  tcadd_pkg::ctx_t    s3_ctx_nxt, s3_ctx_r;
  logic [32:0]        s3_x_nxt, s3_x_r;

  // divider outputs
  tcadd_pkg::ctx_t    dv_ctx;
  logic [6:0]         dv_q;
  tcadd_pkg::ms_t     dv_r;

  // stage 7
  logic signed [10:0] day0;
  logic signed [8:0]  y0;
  tcadd_pkg::ms_t     ms0, ms_nxt;
  logic               extra;
  logic signed [10:0] d1_nxt;
  logic [7:0]         m_nxt;
  logic [3:0]         of_nxt;
  logic               s7_v_r, s7_inday_r, s7_back_r;
  logic [7:0]         s7_ycode_r, s7_dlow_r, s7_m_r;
  logic [3:0]         s7_flags_r, s7_of_r;
  tcadd_pkg::ms_t     s7_ms_r;
  logic signed [10:0] s7_d_r;
  logic signed [8:0]  s7_y_r;

  // stage 8
  logic signed [8:0]  ym1;
  logic               wrap_back;
  logic               s8_v_r, s8_inday_r, s8_back_r;
  logic [7:0]         s8_ycode_r, s8_dlow_r, s8_m_r;
  logic [3:0]         s8_flags_r, s8_of_r;
  tcadd_pkg::ms_t     s8_ms_r;
  logic signed [10:0] s8_d_r;
  logic signed [8:0]  s8_y_r;

  // stage 9, output register
  logic [8:0]         yl9;
  logic signed [10:0] d2_sum, d9;
  logic signed [8:0]  y9;
  logic               s9_v_r, s9_inday_r;
  logic [7:0]         o_year_r, o_day_r;
  tcadd_pkg::ms_t     o_ms_r;
  logic [3:0]         o_flags_r;

  // configuration
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndl_r <= tcadd_pkg::LEAP_NONE;
    end else if (cfg_if.valid) begin
      ndl_r <= cfg_if.next_day_leap;
    end
  end

  assign adv         = !s9_v_r || out_if.ready;
  assign in_if.ready = adv;

  // stage 1: sum and day lengths
  assign sum_nxt = $signed({{2{in_if.add_ms[31]}}, in_if.add_ms})
                 + $signed({7'd0, in_if.day_ms});

  always_comb begin
    lim_nxt = tcadd_pkg::DAY_MS_NORM;
    if (in_if.leap_flags[3]) lim_nxt = tcadd_pkg::DAY_MS_POS;
    if (in_if.leap_flags[2]) lim_nxt = tcadd_pkg::DAY_MS_NEG;
    case (ndl_r)
      tcadd_pkg::LEAP_POS: begin
        lim2_nxt  = tcadd_pkg::DAY_MS_POS;
        ocode_nxt = tcadd_pkg::FLAG_POS;
      end
      tcadd_pkg::LEAP_NEG: begin
        lim2_nxt  = tcadd_pkg::DAY_MS_NEG;
        ocode_nxt = tcadd_pkg::FLAG_NEG;
      end
      default: begin
        lim2_nxt  = tcadd_pkg::DAY_MS_NORM;
        ocode_nxt = tcadd_pkg::FLAG_NONE;
      end
    endcase
  end

  // stage 3 selection
  assign x2_nxt  = s2_r1_r - $signed({7'd0, s2_lim2_r}) - 34'sd1;
  assign two_nxt = !x2_nxt[33] && !s2_back_r && !s2_inday_r;

  always_comb begin
    s3_ctx_nxt.v     = s2_v_r;
    s3_ctx_nxt.inday = s2_inday_r;
    s3_ctx_nxt.back  = s2_back_r;
    s3_ctx_nxt.two   = two_nxt;
    s3_ctx_nxt.ycode = s2_ycode_r;
    s3_ctx_nxt.dlow  = s2_dlow_r;
    s3_ctx_nxt.flags = s2_flags_r;
    s3_ctx_nxt.ms_in = s2_inday_r ? s2_sum_lo_r : s2_r1_r[26:0];
    s3_ctx_nxt.lim   = s2_lim_r;
    s3_ctx_nxt.ocode = s2_ocode_r;
    if (s2_back_r) begin
      s3_x_nxt = s2_xb_r;
    end else if (two_nxt) begin
      s3_x_nxt = x2_nxt[32:0];
    end else begin
      s3_x_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_ctx_r <= '0;
      s7_v_r   <= 1'b0;
      s8_v_r   <= 1'b0;
      s9_v_r   <= 1'b0;
    end else if (adv) begin
      s1_v_r   <= in_if.valid;
      s2_v_r   <= s1_v_r;
      s3_ctx_r <= s3_ctx_nxt;
      s7_v_r   <= dv_ctx.v;
      s8_v_r   <= s7_v_r;
      s9_v_r   <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ycode_r  <= in_if.year_code;
      s1_dlow_r   <= in_if.day_low;
      s1_flags_r  <= in_if.leap_flags;
      s1_sum_r    <= sum_nxt;
      s1_lim_r    <= lim_nxt;
      s1_lim2_r   <= lim2_nxt;
      s1_ocode_r  <= ocode_nxt;

      s2_inday_r  <= !s1_sum_r[33] && (s1_sum_r <= $signed({7'd0, s1_lim_r}));
      s2_back_r   <= s1_sum_r[33];
      s2_r1_r     <= s1_sum_r - $signed({7'd0, s1_lim_r});
      s2_xb_r     <= ~s1_sum_r[32:0];
      s2_sum_lo_r <= s1_sum_r[26:0];
      s2_ycode_r  <= s1_ycode_r;
      s2_dlow_r   <= s1_dlow_r;
      s2_flags_r  <= s1_flags_r;
      s2_lim_r    <= s1_lim_r;
      s2_lim2_r   <= s1_lim2_r;
      s2_ocode_r  <= s1_ocode_r;
      s3_x_r      <= s3_x_nxt;
    end
  end

  tcadd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .ctx_i (s3_ctx_r),
    .x_i   (s3_x_r),
    .ctx_o (dv_ctx),
    .q_o   (dv_q),
    .r_o   (dv_r)
  );

  // stage 7: final ms and day delta
  assign day0  = $signed({2'b00, dv_ctx.ycode[0], dv_ctx.dlow});
  assign y0    = $signed({2'b00, dv_ctx.ycode[7:1]});
  assign ms0   = tcadd_pkg::DAY_MS_NORM - 27'd1 - dv_r;
  assign extra = ms0 > dv_ctx.lim;

  always_comb begin
    ms_nxt = dv_ctx.ms_in;
    d1_nxt = day0;
    m_nxt  = 8'd0;
    of_nxt = tcadd_pkg::FLAG_NONE;
    if (dv_ctx.inday) begin
      m_nxt = 8'd0;
    end else if (dv_ctx.back) begin
      ms_nxt = extra ? (ms0 - dv_ctx.lim) : ms0;
      d1_nxt = day0 - $signed({4'd0, dv_q}) - 11'sd1;
      m_nxt  = {7'd0, extra};
    end else if (dv_ctx.two) begin
      ms_nxt = dv_r + 27'd1;
      m_nxt  = {1'b0, dv_q} + 8'd2;
    end else begin
      m_nxt  = 8'd1;
      of_nxt = dv_ctx.ocode;
    end
  end

  // stage 8: borrow a year
  assign ym1       = s7_y_r - 9'sd1;
  assign wrap_back = s7_back_r && (s7_d_r <= 11'sd0);

  // stage 9: carry a year
  assign yl9    = tcadd_pkg::year_len(s8_y_r);
  assign d2_sum = s8_d_r + $signed({3'd0, s8_m_r});

  always_comb begin
    y9 = s8_y_r;
    d9 = d2_sum;
    if ((s8_m_r != 8'd0) && (d2_sum > $signed({2'b00, yl9}))) begin
      y9 = s8_y_r + 9'sd1;
      d9 = d2_sum - $signed({2'b00, yl9});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_inday_r <= dv_ctx.inday;
      s7_back_r  <= dv_ctx.back;
      s7_ycode_r <= dv_ctx.ycode;
      s7_dlow_r  <= dv_ctx.dlow;
      s7_flags_r <= dv_ctx.flags;
      s7_ms_r    <= ms_nxt;
      s7_d_r     <= d1_nxt;
      s7_m_r     <= m_nxt;
      s7_y_r     <= y0;
      s7_of_r    <= of_nxt;

      s8_inday_r <= s7_inday_r;
      s8_back_r  <= s7_back_r;
      s8_ycode_r <= s7_ycode_r;
      s8_dlow_r  <= s7_dlow_r;
      s8_flags_r <= s7_flags_r;
      s8_ms_r    <= s7_ms_r;
      s8_m_r     <= s7_m_r;
      s8_of_r    <= s7_of_r;
      s8_y_r     <= wrap_back ? ym1 : s7_y_r;
      s8_d_r     <= wrap_back ? (s7_d_r + $signed({2'b00, tcadd_pkg::year_len(ym1)}))
                              : s7_d_r;

      s9_inday_r <= s8_inday_r;
      o_ms_r     <= s8_ms_r;
      if (s8_inday_r) begin
        o_year_r  <= s8_ycode_r;
        o_day_r   <= s8_dlow_r;
        o_flags_r <= s8_flags_r;
      end else begin
        o_year_r  <= {y9[6:0], (d9 >= 11'sd256)};
        o_day_r   <= d9[7:0];
        o_flags_r <= s8_of_r;
      end
    end
  end

  assign out_if.valid          = s9_v_r;
  assign out_if.new_year_code  = o_year_r;
  assign out_if.new_day_low    = o_day_r;
  assign out_if.new_day_ms     = o_ms_r;
  assign out_if.new_leap_flags = o_flags_r;

  // remainder of the reciprocal divide stays below one day
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_ctx.v && (dv_ctx.back || dv_ctx.two) |-> dv_r < tcadd_pkg::DAY_MS_NORM)
    else $error("divider remainder out of range");

  // a borrowed year leaves a positive day
  a_back_day: assert property (@(posedge clk) disable iff (!rst_n)
    s8_v_r && s8_back_r |-> s8_d_r > 11'sd0)
    else $error("day not positive after year borrow");

  // result ms never exceed the longest day
  a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.new_day_ms <= tcadd_pkg::DAY_MS_POS)
    else $error("result ms out of range");

  // a day change carries at most one leap flag and clears the low bits
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !s9_inday_r |->
      (out_if.new_leap_flags[1:0] == 2'b00) && $onehot0(out_if.new_leap_flags[3:2]))
    else $error("bad leap flags on day change");

endmodule

// ===== bench/time_code_add_milliseconds_tb.sv =====
// self-checking testbench for the time code millisecond adder
module time_code_add_milliseconds_tb;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [7:0]         yc;
    logic [7:0]         dlow;
    logic [26:0]        dms;
    logic [3:0]         flags;
    logic signed [31:0] add;
  } tc_req_t;

  typedef struct {
    logic [7:0]  yc;
    logic [7:0]  dlow;
    logic [26:0] dms;
    logic [3:0]  flags;
  } tc_res_t;

  logic clk;
  logic rst_n;

  tcadd_in_if  in_if();
  tcadd_out_if out_if();
  tcadd_cfg_if cfg_if();

  time_code_add_milliseconds u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_if(cfg_if.sink),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  tc_req_t pending_reqs[$];
  tc_res_t expected_codes[$];
  int      leap_setting;
  int      in_idle_pct;
  int      out_idle_pct;
  int      errors;
  int      cycles;
  bit      in_taken;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int days_in_year(int yr);
    bit lp;
    lp = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    return lp ? 366 : 365;
  endfunction

  function automatic tc_res_t add_offset(tc_req_t r, int leap);
    tc_res_t o;
    longint  sum;
    longint  ms;
    longint  lim;
    int      yr;
    int      day;
    int      net;
    int      n;
    logic [7:0] yc;
    sum = longint'(r.dms) + longint'(r.add);
    ms = sum;
    net = 0;
    lim = tcadd_pkg::DAY_MS_NORM;
    if (r.flags[3]) lim = tcadd_pkg::DAY_MS_POS;
    if (r.flags[2]) lim = tcadd_pkg::DAY_MS_NEG;
    if (sum >= 0 && sum <= lim) begin
      o.yc = r.yc;
      o.dlow = r.dlow;
      o.dms = sum[26:0];
      o.flags = r.flags;
      return o;
    end
    yr = 1970 + int'(r.yc[7:1]);
    day = int'(r.dlow) + (r.yc[0] ? 256 : 0);
    if (ms < 0) begin
      while (ms < 0) begin
        ms += tcadd_pkg::DAY_MS_NORM;
        day--;
        net--;
      end
      if (day <= 0) begin
        yr--;
        day += days_in_year(yr);
      end
    end
    while (ms > lim) begin
      day++;
      net++;
      ms -= lim;
      lim = tcadd_pkg::DAY_MS_NORM;
      if (net == 1) begin
        if (leap == 1) lim = tcadd_pkg::DAY_MS_POS;
        if (leap == -1) lim = tcadd_pkg::DAY_MS_NEG;
      end
      n = days_in_year(yr);
      if (day > n) begin
        yr++;
        day -= n;
      end
    end
    o.flags = tcadd_pkg::FLAG_NONE;
    if (sum > 0 && net == 1) begin
      if (leap == 1) o.flags = tcadd_pkg::FLAG_POS;
      if (leap == -1) o.flags = tcadd_pkg::FLAG_NEG;
    end
    yc = 8'((yr - 1970) * 2) & 8'hFE;
    if (day >= 256) yc[0] = 1'b1;
    o.yc = yc;
    o.dlow = 8'(day);
    o.dms = ms[26:0];
    return o;
  endfunction

  function automatic tc_req_t rand_req();
    tc_req_t r;
    int      day;
    int      lim;
    int      pick;
    int      days[10] = '{0, 1, 2, 254, 255, 256, 364, 365, 366, 367};
    if ($urandom_range(0, 9) < 7) day = days[$urandom_range(0, 9)];
    else day = $urandom_range(0, 511);
    r.yc = {7'($urandom), day[8]};
    r.dlow = day[7:0];
    r.flags = 4'($urandom);
    lim = r.flags[2] ? 86399000 : (r.flags[3] ? 86401000 : 86400000);
    pick = $urandom_range(0, 3);
    if (pick == 0) r.dms = 27'($urandom_range(0, 2000));
    else if (pick == 1) r.dms = 27'(86401000 - $urandom_range(0, 3000));
    else r.dms = 27'($urandom_range(0, 86401000));
    pick = $urandom_range(0, 6);
    case (pick)
      0: r.add = $urandom_range(0, 4000) - 2000;
      1: r.add = lim - int'(r.dms) + $urandom_range(0, 2000) - 1000;
      2: r.add = -int'(r.dms) + $urandom_range(0, 2000) - 1000;
      3: r.add = $urandom_range(0, 24) * 86400000 + $urandom_range(0, 2000) - 1000;
      4: r.add = -$urandom_range(0, 24) * 86400000 + $urandom_range(0, 2000) - 1000;
      5: r.add = lim - int'(r.dms) + 86400000 + $urandom_range(0, 4000) - 2000;
      default: r.add = $urandom;
    endcase
    return r;
  endfunction

  function automatic tc_req_t mk_req(logic [7:0] yc, logic [7:0] dl, logic [26:0] dms,
                                     logic [3:0] fl, logic signed [31:0] add);
    tc_req_t r;
    r.yc = yc; r.dlow = dl; r.dms = dms; r.flags = fl; r.add = add;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_codes.size() != 0 || in_if.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_leap(int v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.next_day_leap <= 2'(v);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    leap_setting = (v == -2) ? 0 : v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // request driver and random out_if.ready
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        tc_req_t r;
        r = pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        in_if.year_code <= r.yc;
        in_if.day_low <= r.dlow;
        in_if.day_ms <= r.dms;
        in_if.leap_flags <= r.flags;
        in_if.add_ms <= r.add;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && ($urandom_range(0, 99) >= out_idle_pct);
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    tc_req_t r;
    tc_res_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("time_code_add_milliseconds regression: fail");
      $finish;
    end
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      r = mk_req(in_if.year_code, in_if.day_low, in_if.day_ms, in_if.leap_flags, in_if.add_ms);
      expected_codes.push_back(add_offset(r, leap_setting));
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_codes.size() == 0) begin
        $display("%0t unexpected result %h %h %h %h", $realtime, out_if.new_year_code,
                 out_if.new_day_low, out_if.new_day_ms, out_if.new_leap_flags);
        errors++;
      end else begin
        e = expected_codes.pop_front();
        if (out_if.new_year_code !== e.yc || out_if.new_day_low !== e.dlow ||
            out_if.new_day_ms !== e.dms || out_if.new_leap_flags !== e.flags) begin
          $display("%0t mismatch exp %h %h %0d %h got %h %h %0d %h", $realtime,
                   e.yc, e.dlow, e.dms, e.flags, out_if.new_year_code, out_if.new_day_low,
                   out_if.new_day_ms, out_if.new_leap_flags);
          errors++;
        end
      end
    end
  end

  initial begin
    int leaps[6] = '{1, -1, 0, -2, 1, -1};
    int idle_in[3] = '{18, 73, 0};
    int idle_out[3] = '{73, 18, 0};
    errors = 0;
    cycles = 0;
    in_taken = 1'b0;
    leap_setting = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.year_code = '0;
    in_if.day_low = '0;
    in_if.day_ms = '0;
    in_if.leap_flags = '0;
    in_if.add_ms = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.next_day_leap = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_leap(1);
    // directed corners
    pending_reqs.push_back(mk_req(8'd0, 8'd1, 27'd0, 4'h0, 32'sd0));
    pending_reqs.push_back(mk_req(8'd0, 8'd1, 27'd0, 4'h0, -32'sd1));
    pending_reqs.push_back(mk_req(8'd255, 8'd109, 27'd86399999, 4'h3, 32'sd1));
    pending_reqs.push_back(mk_req(8'd60, 8'd109, 27'd86399999, 4'h0, 32'sd1));
    pending_reqs.push_back(mk_req(8'd10, 8'd50, 27'd86400000, 4'h0, 32'sd0));
    pending_reqs.push_back(mk_req(8'd10, 8'd50, 27'd86400000, 4'h8, 32'sd1000));
    pending_reqs.push_back(mk_req(8'd10, 8'd50, 27'd86401000, 4'h8, 32'sd1));
    pending_reqs.push_back(mk_req(8'd10, 8'd50, 27'd86399000, 4'h4, 32'sd1));
    pending_reqs.push_back(mk_req(8'd10, 8'd50, 27'd86399500, 4'hC, 32'sd0));
    pending_reqs.push_back(mk_req(8'd10, 8'd50, 27'd1000, 4'hF, 32'sd86400000));
    pending_reqs.push_back(mk_req(8'd20, 8'd50, 27'd0, 4'h0, 32'sh7FFFFFFF));
    pending_reqs.push_back(mk_req(8'd20, 8'd50, 27'd0, 4'h0, 32'sh80000000));
    pending_reqs.push_back(mk_req(8'd255, 8'd255, 27'd86401000, 4'hF, 32'sh7FFFFFFF));
    pending_reqs.push_back(mk_req(8'd0, 8'd0, 27'd0, 4'h0, 32'sh80000000));
    pending_reqs.push_back(mk_req(8'd61, 8'd109, 27'd5, 4'h2, -32'sd6));
    pending_reqs.push_back(mk_req(8'd60, 8'd1, 27'd5, 4'h1, -32'sd6));
    pending_reqs.push_back(mk_req(8'd61, 8'd110, 27'd86000000, 4'h0, 32'sd1000000));
    pending_reqs.push_back(mk_req(8'd1, 8'd255, 27'd100, 4'h0, -32'sd200));
    pending_reqs.push_back(mk_req(8'd0, 8'd255, 27'd86399990, 4'h0, 32'sd20));
    pending_reqs.push_back(mk_req(8'd100, 8'd0, 27'd0, 4'h0, 32'sd172800000));
    wait_drained();
    for (int k = 0; k < 6; k++) begin
      write_leap(leaps[k]);
      in_idle_pct = idle_in[k / 2];
      out_idle_pct = idle_out[k / 2];
      for (int i = 0; i < 272; i++) pending_reqs.push_back(rand_req());
      wait_drained();
    end
    repeat (30) @(posedge clk);
    if (errors == 0) $display("time_code_add_milliseconds regression: pass");
    else $display("time_code_add_milliseconds regression: fail");
    $finish;
  end

endmodule
